@@ hw/rtl/sbe_pkg.sv @@
// Shared types and constants for the stochastic bitstream encoder.
package sbe_pkg;

  localparam int MAX_STREAM_LENGTH = 64;
  localparam int VALUE_FRAC_BITS   = 16;

  localparam int VALUE_W  = VALUE_FRAC_BITS + 1;
  localparam int LEN_W    = 7;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = VALUE_W + DATA_W;
  localparam int STEP_W   = PROD_W - VALUE_FRAC_BITS;
  localparam int ACC_W    = DATA_W + 2;
  localparam int ADDR_W   = 4;

  localparam logic [VALUE_W-1:0] VALUE_ONE  = VALUE_W'(1) << VALUE_FRAC_BITS;
  localparam logic [VALUE_W-1:0] VALUE_HALF = VALUE_W'(1) << (VALUE_FRAC_BITS - 1);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (VALUE_FRAC_BITS - 1);

  localparam logic [DATA_W-1:0] LFSR_DEFAULT = 32'h0000_ACE1;
  localparam logic [DATA_W-1:0] LFSR_POLY    = 32'h8020_0003;
  localparam logic [DATA_W-1:0] FULL_SCALE   = 32'hFFFF_FFFF;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_STREAM_LENGTH);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  localparam logic [1:0] MODE_BINARY = 2'd0;
  localparam logic [1:0] MODE_DELTA  = 2'd1;
  localparam logic [1:0] MODE_LFSR   = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  typedef struct packed {
    logic [1:0]        encoding_mode;
    logic [LEN_W-1:0]  bits_per_word;
    logic [DATA_W-1:0] ds_scale;
    logic [DATA_W-1:0] lfsr_seed;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic prep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic final_bit;
  } sts_t;

endpackage

@@ hw/rtl/stochastic_bitstream_encoder_core.sv @@
// Top level of the stochastic bitstream encoder: registers, controller and datapath.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   feature_value[16:0]
//  output    out        out_valid / out_stall stream_bit, last_bit
//  config    in         psel/penable/pready   paddr[3:0], pwdata[31:0], prdata[31:0]
//
// Each word passes through the multiplier and prepare steps, then one bit per cycle while the output is not stalled.
// The input is stalled from an accepted word until its final bit is emitted; binary mode gives a single bit per word.
// The next word is accepted once the final bit sits in the output register.
// A stalled output holds the bit generator until the register is taken.
// Reset is synchronous and restores the register defaults and an empty output.
module stochastic_bitstream_encoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbe_pkg::VALUE_W-1:0]  feature_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         stream_bit,
  output logic                         last_bit,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbe_pkg::ADDR_W-1:0]   paddr,
  input  logic [sbe_pkg::DATA_W-1:0]   pwdata,
  output logic [sbe_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  sbe_pkg::cfg_t cfg;
  sbe_pkg::cmd_t cmd;
  sbe_pkg::sts_t sts;

  sbe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbe_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .feature_value (feature_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stream_bit    (stream_bit),
    .last_bit      (last_bit)
  );

endmodule

@@ hw/rtl/sbe_regs.sv @@
// Configuration register file behind the APB-style port.
module sbe_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbe_pkg::DATA_W-1:0]  pwdata,
  output logic [sbe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output sbe_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.encoding_mode <= sbe_pkg::MODE_BINARY;
      cfg.bits_per_word <= sbe_pkg::LEN_MAX;
      cfg.ds_scale      <= 32'h0001_0000;
      cfg.lfsr_seed     <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        sbe_pkg::REG_MODE:   cfg.encoding_mode <= pwdata[1:0];
        sbe_pkg::REG_LENGTH: cfg.bits_per_word <= pwdata[sbe_pkg::LEN_W-1:0];
        sbe_pkg::REG_SCALE:  cfg.ds_scale      <= pwdata;
        sbe_pkg::REG_SEED:   cfg.lfsr_seed     <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sbe_pkg::REG_MODE:   prdata = {30'd0, cfg.encoding_mode};
      sbe_pkg::REG_LENGTH: prdata = {{(sbe_pkg::DATA_W-sbe_pkg::LEN_W){1'b0}},
                                     cfg.bits_per_word};
      sbe_pkg::REG_SCALE:  prdata = cfg.ds_scale;
      sbe_pkg::REG_SEED:   prdata = cfg.lfsr_seed;
    endcase
  end

endmodule

@@ hw/rtl/sbe_ctrl.sv @@
// Controller state machine that sequences one feature word through the datapath.
module sbe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sbe_pkg::sts_t sts,
  output sbe_pkg::cmd_t cmd
);

  sbe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      sbe_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sbe_pkg::S_MUL;
        end
      end
      sbe_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sbe_pkg::S_PREP;
      end
      sbe_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sbe_pkg::S_RUN;
      end
      sbe_pkg::S_RUN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.final_bit) begin
            state_next = sbe_pkg::S_IDLE;
          end
        end
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == sbe_pkg::S_MUL)
    else $error("accepted word did not start the multiply step");

  a_mul_then_prep: assert property (@(posedge clk) disable iff (rst)
    state == sbe_pkg::S_MUL |=> state == sbe_pkg::S_PREP)
    else $error("multiply step not followed by prepare step");

  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (state == sbe_pkg::S_RUN && !(cmd.emit && sts.final_bit)) |=> state == sbe_pkg::S_RUN)
    else $error("stream left before its final bit");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.final_bit) |=> state == sbe_pkg::S_IDLE)
    else $error("final bit did not return the controller to idle");

endmodule

@@ hw/rtl/sbe_dpath.sv @@
// Datapath: multiplier, delta-sigma accumulator, LFSR, bit counter and output register.
module sbe_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  sbe_pkg::cfg_t                cfg,
  input  sbe_pkg::cmd_t                cmd,
  output sbe_pkg::sts_t                sts,
  input  logic [sbe_pkg::VALUE_W-1:0]  feature_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         stream_bit,
  output logic                         last_bit
);

  logic [sbe_pkg::VALUE_W-1:0] value;
  logic [sbe_pkg::VALUE_W-1:0] value_sat;
  logic [sbe_pkg::PROD_W-1:0]  prod;
  logic [sbe_pkg::PROD_W-1:0]  prod_rnd;
  logic [sbe_pkg::STEP_W-1:0]  step_or_threshold;
  logic signed [sbe_pkg::ACC_W-1:0] sigma_accumulator;
  logic signed [sbe_pkg::ACC_W-1:0] acc_sum;
  logic signed [sbe_pkg::ACC_W-1:0] acc_thr;
  logic signed [sbe_pkg::ACC_W-1:0] acc_scale;
  logic [sbe_pkg::DATA_W-1:0]  lfsr_register;
  logic [sbe_pkg::DATA_W-1:0]  lfsr_next;
  logic [sbe_pkg::DATA_W-1:0]  mul_operand;
  logic [sbe_pkg::LEN_W-1:0]   bit_counter;
  logic [sbe_pkg::LEN_W-1:0]   len_eff;
  logic                        is_delta;
  logic                        is_lfsr;
  logic                        delta_bit;
  logic                        bit_value;

  assign is_delta = cfg.encoding_mode == sbe_pkg::MODE_DELTA;
  assign is_lfsr  = cfg.encoding_mode == sbe_pkg::MODE_LFSR;

  assign value_sat = (feature_value > sbe_pkg::VALUE_ONE) ? sbe_pkg::VALUE_ONE
                                                          : feature_value;

  always_comb begin
    if (!(is_delta || is_lfsr)) begin
      len_eff = sbe_pkg::LEN_ONE;
    end else if (cfg.bits_per_word == '0) begin
      len_eff = sbe_pkg::LEN_ONE;
    end else if (cfg.bits_per_word > sbe_pkg::LEN_MAX) begin
      len_eff = sbe_pkg::LEN_MAX;
    end else begin
      len_eff = cfg.bits_per_word;
    end
  end

  assign mul_operand = is_delta ? cfg.ds_scale : sbe_pkg::FULL_SCALE;
  assign prod_rnd    = prod + (is_delta ? sbe_pkg::ROUND_HALF : '0);

  assign acc_scale = $signed({2'b00, cfg.ds_scale});
  assign acc_thr   = $signed({3'b000, cfg.ds_scale[sbe_pkg::DATA_W-1:1]});
  assign acc_sum   = sigma_accumulator
                   + $signed({{(sbe_pkg::ACC_W-sbe_pkg::STEP_W){1'b0}}, step_or_threshold});
  assign delta_bit = acc_sum > acc_thr;

  assign lfsr_next = (lfsr_register >> 1) ^ (lfsr_register[0] ? sbe_pkg::LFSR_POLY : '0);

  always_comb begin
    if (is_delta) begin
      bit_value = delta_bit;
    end else if (is_lfsr) begin
      bit_value = {1'b0, lfsr_next} <= step_or_threshold;
    end else begin
      bit_value = value >= sbe_pkg::VALUE_HALF;
    end
  end

  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.final_bit = bit_counter == len_eff - sbe_pkg::LEN_ONE;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= value_sat;
    end
    if (cmd.mul) begin
      prod <= value * mul_operand;
    end
    if (cmd.prep) begin
      step_or_threshold <= prod_rnd[sbe_pkg::PROD_W-1:sbe_pkg::VALUE_FRAC_BITS];
      sigma_accumulator <= '0;
      lfsr_register     <= (cfg.lfsr_seed != '0) ? cfg.lfsr_seed : sbe_pkg::LFSR_DEFAULT;
    end else if (cmd.emit) begin
      if (is_delta) begin
        sigma_accumulator <= delta_bit ? acc_sum - acc_scale : acc_sum;
      end
      if (is_lfsr) begin
        lfsr_register <= lfsr_next;
      end
    end
    if (cmd.emit) begin
      stream_bit <= bit_value;
      last_bit   <= sts.final_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.prep) begin
        bit_counter <= '0;
      end else if (cmd.emit) begin
        bit_counter <= bit_counter + sbe_pkg::LEN_ONE;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
